FILE: hw/rtl/dms_pkg.sv
package dms_pkg;

  localparam int KEY_W = 32;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS,
    S_SEG,
    S_RD,
    S_MRG,
    S_FETCH,
    S_OUT,
    S_WAIT
  } dms_state_t;

  typedef struct packed {
    logic store;
    logic start_sort;
    logic seg_start;
    logic pass_next;
    logic seg_setup;
    logic merge_step;
    logic rd_emit;
    logic emit_adv;
    logic clear;
  } dms_cmd_t;

  typedef struct packed {
    logic width_done;
    logic seg_done;
    logic merge_last;
    logic emit_final;
  } dms_sts_t;

endpackage

FILE: hw/rtl/dms_ctrl.sv
module dms_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tlast,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  dms_pkg::dms_sts_t sts,
  output dms_pkg::dms_cmd_t cmd
);
  import dms_pkg::*;

  dms_state_t state_r;
  dms_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_tvalid && in_tlast) state_nxt = S_PASS;
      end
      S_PASS: begin
        state_nxt = sts.width_done ? S_FETCH : S_SEG;
      end
      S_SEG: begin
        state_nxt = sts.seg_done ? S_PASS : S_RD;
      end
      S_RD: begin
        state_nxt = S_MRG;
      end
      S_MRG: begin
        state_nxt = sts.merge_last ? S_SEG : S_RD;
      end
      S_FETCH: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = sts.emit_final ? S_LOAD : S_WAIT;
      end
      S_WAIT: begin
        if (in_tvalid) state_nxt = S_FETCH;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_tready      = 1'b1;
        cmd.store      = in_tvalid;
        cmd.start_sort = in_tvalid && in_tlast;
      end
      S_PASS: begin
        cmd.seg_start = !sts.width_done;
      end
      S_SEG: begin
        cmd.pass_next = sts.seg_done;
        cmd.seg_setup = !sts.seg_done;
      end
      S_RD: begin
        cmd.rd_emit = 1'b0;
      end
      S_MRG: begin
        cmd.merge_step = 1'b1;
      end
      S_FETCH: begin
        cmd.rd_emit = 1'b1;
      end
      S_OUT: begin
        out_tvalid   = 1'b1;
        cmd.rd_emit  = 1'b1;
        cmd.clear    = out_tready && sts.emit_final;
        cmd.emit_adv = out_tready && !sts.emit_final;
      end
      S_WAIT: begin
        in_tready   = 1'b1;
        cmd.rd_emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output handshakes open together");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_tready) |=> (state_r == S_OUT))
    else $error("stalled result dropped");

  a_sort_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS && sts.width_done) |=> (state_r == S_FETCH))
    else $error("finished sort did not fetch rank 0");
`endif

endmodule

FILE: hw/rtl/dms_datapath.sv
module dms_datapath #(
  parameter int CAPACITY  = 256,
  parameter int TAG_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dms_pkg::dms_cmd_t          cmd,
  output dms_pkg::dms_sts_t          sts,
  input  logic [dms_pkg::KEY_W-1:0]  in_key,
  input  logic [TAG_WIDTH-1:0]       in_tag,
  output logic [dms_pkg::KEY_W-1:0]  out_key,
  output logic [TAG_WIDTH-1:0]       out_tag,
  output logic                       out_final,
  output logic                       out_ovf
);
  import dms_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int SUM_W  = CNT_W + 2;
  localparam int REC_W  = KEY_W + TAG_WIDTH;

  typedef logic [REC_W-1:0] rec_t;

  rec_t mem_a [CAPACITY];
  rec_t mem_b [CAPACITY];
  rec_t rd_a0_r, rd_a1_r, rd_b0_r, rd_b1_r;
  rec_t rd0, rd1, wdata;

  logic [CNT_W-1:0] fill_r, emit_r, mid_r, hi_r, i_r, j_r, k_r;
  logic [SUM_W-1:0] width_r, lo_r;
  logic             ovf_r, sel_r;

  logic [SUM_W-1:0]  n_ext, lo_w, lo_2w, mid_sum, hi_sum;
  logic [ADDR_W-1:0] ra0, ra1, waddr;
  logic              room, take_left, we_a, we_b;

  assign n_ext   = SUM_W'(fill_r);
  assign lo_w    = lo_r + width_r;
  assign lo_2w   = lo_r + (width_r << 1);
  assign mid_sum = (lo_w >= n_ext) ? n_ext : lo_w;
  assign hi_sum  = (lo_2w >= n_ext) ? n_ext : lo_2w;
  assign room    = fill_r < CNT_W'(CAPACITY);

  assign rd0 = sel_r ? rd_b0_r : rd_a0_r;
  assign rd1 = sel_r ? rd_b1_r : rd_a1_r;

  // take the left head on ties to keep the sort stable
  assign take_left = (i_r < mid_r) &&
                     ((j_r >= hi_r) ||
                      ($signed(rd0[KEY_W-1:0]) >= $signed(rd1[KEY_W-1:0])));

  assign wdata = cmd.store ? {in_tag, in_key} : (take_left ? rd0 : rd1);
  assign waddr = cmd.store ? fill_r[ADDR_W-1:0] : k_r[ADDR_W-1:0];
  assign we_a  = (cmd.store && room) || (cmd.merge_step && sel_r);
  assign we_b  = cmd.merge_step && !sel_r;

  assign ra0 = cmd.rd_emit ? emit_r[ADDR_W-1:0] : i_r[ADDR_W-1:0];
  assign ra1 = j_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (we_a) mem_a[waddr] <= wdata;
    rd_a0_r <= mem_a[ra0];
    rd_a1_r <= mem_a[ra1];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[waddr] <= wdata;
    rd_b0_r <= mem_b[ra0];
    rd_b1_r <= mem_b[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      ovf_r   <= 1'b0;
      sel_r   <= 1'b0;
      emit_r  <= '0;
      width_r <= '0;
      lo_r    <= '0;
      mid_r   <= '0;
      hi_r    <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.store) begin
        if (room) fill_r <= fill_r + CNT_W'(1);
        else      ovf_r  <= 1'b1;
      end
      if (cmd.start_sort) width_r <= SUM_W'(1);
      if (cmd.seg_start)  lo_r    <= '0;
      if (cmd.pass_next) begin
        width_r <= width_r << 1;
        sel_r   <= ~sel_r;
      end
      if (cmd.seg_setup) begin
        mid_r <= mid_sum[CNT_W-1:0];
        hi_r  <= hi_sum[CNT_W-1:0];
        i_r   <= lo_r[CNT_W-1:0];
        j_r   <= mid_sum[CNT_W-1:0];
        k_r   <= lo_r[CNT_W-1:0];
      end
      if (cmd.merge_step) begin
        if (take_left) i_r <= i_r + CNT_W'(1);
        else           j_r <= j_r + CNT_W'(1);
        k_r <= k_r + CNT_W'(1);
        if (sts.merge_last) lo_r <= lo_2w;
      end
      if (cmd.emit_adv) emit_r <= emit_r + CNT_W'(1);
      if (cmd.clear) begin
        fill_r <= '0;
        ovf_r  <= 1'b0;
        sel_r  <= 1'b0;
        emit_r <= '0;
      end
    end
  end

  assign sts.width_done = width_r >= n_ext;
  assign sts.seg_done   = lo_r >= n_ext;
  assign sts.merge_last = (k_r + CNT_W'(1)) == hi_r;
  assign sts.emit_final = (emit_r + CNT_W'(1)) >= fill_r;

  assign out_key   = rd0[KEY_W-1:0];
  assign out_tag   = rd0[REC_W-1:KEY_W];
  assign out_final = sts.emit_final;
  assign out_ovf   = ovf_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count past capacity");

  a_head_avail: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_step |-> ((i_r < mid_r) || (j_r < hi_r)))
    else $error("merge step with both runs exhausted");

  a_k_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_step |-> (k_r < hi_r))
    else $error("merge write beyond segment end");
`endif

endmodule

FILE: hw/rtl/descending_merge_sorter_top.sv
// Descending stable merge sorter. Stream in records (key in tdata[31:0], tag above it) until a
// word with in_tlast set; the block then sorts the set by signed Q16.16 key, largest first,
// with earlier records winning ties, and holds rank 0 on the output. Each further input word
// (its contents are ignored) pulls the next rank; out_tlast marks the final rank, after which
// the next input word starts a new set. Records beyond CAPACITY are dropped and out_tuser is
// set on every result of that set. Loading accepts one word per cycle. The sort is a
// bottom-up merge over two ping-pong banks of CAPACITY entries; each merge step reads both run
// heads from the source bank and writes one record to the other, so a set of n records takes
// ceil(log2 n) passes. Each result is then fetched through the registered bank read port and
// waits in the output until taken. Only one word is in flight at a time.
module descending_merge_sorter_top #(
  parameter int CAPACITY  = 256,
  parameter int TAG_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // fields from bit 0: sort_key (32), record_tag (TAG_WIDTH), zero fill to bytes
  input  logic [((dms_pkg::KEY_W + TAG_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // fields from bit 0: sorted_key (32), sorted_tag (TAG_WIDTH), zero fill to bytes
  output logic [((dms_pkg::KEY_W + TAG_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                 out_tlast,
  // fields from bit 0: overflow_flag
  output logic                 out_tuser
);
  import dms_pkg::*;

  localparam int REC_W  = KEY_W + TAG_WIDTH;
  localparam int DATA_W = ((KEY_W + TAG_WIDTH + 7) / 8) * 8;

  dms_cmd_t cmd;
  dms_sts_t sts;

  logic [KEY_W-1:0]     rec_key;
  logic [TAG_WIDTH-1:0] rec_tag;

  // sequence load, sort passes and result fetch
  dms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // record banks, run pointers and merge compare
  dms_datapath #(
    .CAPACITY  (CAPACITY),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_key    (in_tdata[KEY_W-1:0]),
    .in_tag    (in_tdata[REC_W-1:KEY_W]),
    .out_key   (rec_key),
    .out_tag   (rec_tag),
    .out_final (out_tlast),
    .out_ovf   (out_tuser)
  );

  // zero-extend the record to whole bytes
  assign out_tdata = DATA_W'({rec_tag, rec_key});

endmodule
